// ===== rtl/capc_pkg.sv =====
package capc_pkg;

	// Requested operation codes
	typedef enum logic [3:0] {
		OP_DATA_READ  = 4'd0,
		OP_DATA_WRITE = 4'd1,
		OP_DATA_INC   = 4'd2,
		OP_DATA_DEC   = 4'd3,
		OP_KEYA_READ  = 4'd4,
		OP_KEYA_WRITE = 4'd5,
		OP_KEYB_READ  = 4'd6,
		OP_KEYB_WRITE = 4'd7,
		OP_AC_READ    = 4'd8,
		OP_AC_WRITE   = 4'd9
	} op_t;

	// Access bits of one group: {C1, C2, C3}
	typedef logic [2:0] ac_t;

	// Sets of access codes, one bit per code value
	localparam logic [7:0] TR_KEY_WR_B  = 8'h1B;
	localparam logic [7:0] TR_KEY_WR_A  = 8'h03;
	localparam logic [7:0] TR_KEYB_RD   = 8'h07;
	localparam logic [7:0] TR_AC_WR_B   = 8'h2A;
	localparam logic [7:0] DT_RD_A_DENY = 8'hA8;
	localparam logic [7:0] DT_WR_B      = 8'h59;
	localparam logic [7:0] DT_INC_B     = 8'h41;
	localparam logic [7:0] DT_DEC       = 8'h43;

	// Block address split
	localparam int unsigned  BLK_W        = 8;
	localparam int unsigned  SECTOR_W     = 6;
	localparam logic [1:0]   TRAILER_GRP  = 2'd3;
	localparam logic [3:0]   LARGE_GRP1   = 4'd5;
	localparam logic [3:0]   LARGE_GRP2   = 4'd10;
	localparam logic [2:0]   LARGE_SECTOR_BASE = 3'b100;

	// One result item
	typedef struct packed {
		logic                allowed;
		logic                value_block;
		logic                trailer_block;
		logic [SECTOR_W-1:0] sector_index;
	} result_t;

endpackage

// ===== rtl/card_access_permission_check.sv =====
// Channel  | Handshake             | Payload
// ---------+-----------------------+----------------------------------------------
// in       | in_valid / in_stall   | block_number, key_sel, operation,
//          |                       | access_byte_b, access_byte_c
// out      | out_valid / out_stall | allowed, value_block, trailer_block,
//          |                       | sector_index
//
// One transfer per cycle in each direction unless stalled; an accepted request
// loads the input register, and its result then loads the result register.
// The permission decode between the two registers sets the cycle time.
// Reset clears both stage valid flags; payload registers are not reset.
// A stall on out holds the result register; in_stall rises only when both
// stages are full and the result is stalled.
module card_access_permission_check
	import capc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [BLK_W-1:0]    block_number,
	input  logic                key_sel,
	input  logic [3:0]          operation,
	input  logic [7:0]          access_byte_b,
	input  logic [7:0]          access_byte_c,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                allowed,
	output logic                value_block,
	output logic                trailer_block,
	output logic [SECTOR_W-1:0] sector_index
);

	logic             vld_s1;
	logic [BLK_W-1:0] blk_s1;
	logic             key_s1;
	logic [3:0]       op_s1;
	logic [7:0]       acb_s1;
	logic [7:0]       acc_s1;
	logic             vld_s2;
	result_t          res_s2;
	result_t          res_d;
	logic             load_s2;
	logic             load_s1;

	// Pipeline advance
	assign load_s2  = ~vld_s2 | ~out_stall;
	assign in_stall = vld_s1 & ~load_s2;
	assign load_s1  = in_valid & ~in_stall;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (load_s1 | load_s2) vld_s1 <= load_s1;
			if (load_s2) vld_s2 <= vld_s1;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (load_s1) begin
			blk_s1 <= block_number;
			key_s1 <= key_sel;
			op_s1  <= operation;
			acb_s1 <= access_byte_b;
			acc_s1 <= access_byte_c;
		end
	end

	capc_decode u_decode (
		.block_number  (blk_s1),
		.key_sel       (key_s1),
		.operation     (op_s1),
		.access_byte_b (acb_s1),
		.access_byte_c (acc_s1),
		.result        (res_d)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (load_s2 & vld_s1) res_s2 <= res_d;
	end

	assign out_valid     = vld_s2;
	assign allowed       = res_s2.allowed;
	assign value_block   = res_s2.value_block;
	assign trailer_block = res_s2.trailer_block;
	assign sector_index  = res_s2.sector_index;

endmodule

// ===== rtl/capc_decode.sv =====
module capc_decode
	import capc_pkg::*;
(
	input  logic [BLK_W-1:0] block_number,
	input  logic             key_sel,
	input  logic [3:0]       operation,
	input  logic [7:0]       access_byte_b,
	input  logic [7:0]       access_byte_c,
	output result_t          result
);

	logic             small_sec;
	logic             trailer;
	logic [3:0]       offset;
	logic [1:0]       grp;
	ac_t              ac;
	logic             tr_ok;
	logic             dt_ok;
	op_t              op;

	// Block classification: small sectors of 4 below 128, large of 16 from 128 up
	always_comb begin
		small_sec = ~block_number[7];
		offset    = small_sec ? {2'b00, block_number[1:0]} : block_number[3:0];
		trailer   = small_sec ? (block_number[1:0] == 2'b11) : (block_number[3:0] == 4'hF);
		if (trailer) begin
			grp = TRAILER_GRP;
		end else if (small_sec) begin
			grp = offset[1:0];
		end else if (offset < LARGE_GRP1) begin
			grp = 2'd0;
		end else if (offset < LARGE_GRP2) begin
			grp = 2'd1;
		end else begin
			grp = 2'd2;
		end
	end

	// Access bits of the selected group
	assign ac = {access_byte_b[3'd4 + {1'b0, grp}], access_byte_c[grp],
		access_byte_c[3'd4 + {1'b0, grp}]};

	assign op = op_t'(operation);

	// Trailer rules
	always_comb begin
		unique case (op)
			OP_KEYA_WRITE, OP_KEYB_WRITE: tr_ok = key_sel ? TR_KEY_WR_B[ac] : TR_KEY_WR_A[ac];
			OP_KEYB_READ:                 tr_ok = TR_KEYB_RD[ac];
			OP_AC_READ:                   tr_ok = 1'b1;
			OP_AC_WRITE:                  tr_ok = key_sel ? TR_AC_WR_B[ac] : (ac == 3'd1);
			default:                      tr_ok = 1'b0;
		endcase
	end

	// Data block rules
	always_comb begin
		unique case (op)
			OP_DATA_READ:  dt_ok = key_sel ? (ac != 3'd7) : ~DT_RD_A_DENY[ac];
			OP_DATA_WRITE: dt_ok = (key_sel ? DT_WR_B[ac] : (ac == 3'd0))
				& (block_number != '0);
			OP_DATA_INC:   dt_ok = key_sel ? DT_INC_B[ac] : (ac == 3'd0);
			OP_DATA_DEC:   dt_ok = DT_DEC[ac];
			default:       dt_ok = 1'b0;
		endcase
	end

	// Result assembly
	always_comb begin
		result.allowed       = trailer ? tr_ok : dt_ok;
		result.value_block   = ~trailer & ((ac == 3'd6) | (ac == 3'd1));
		result.trailer_block = trailer;
		result.sector_index  = small_sec ? {1'b0, block_number[6:2]}
			: {LARGE_SECTOR_BASE, block_number[6:4]};
	end

endmodule

// ===== rtl/capc_checker.sv =====
module capc_checker
	import capc_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic                allowed,
	input logic                value_block,
	input logic                trailer_block,
	input logic [SECTOR_W-1:0] sector_index
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its fields
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(allowed) && $stable(value_block)
			&& $stable(trailer_block) && $stable(sector_index))
		else $error("result changed while stalled");

	// Trailers never report a value block
	a_trailer_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(trailer_block && value_block))
		else $error("value block flagged on trailer");

	// Sector index stays on the card
	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sector_index <= 6'd39)
		else $error("sector index out of range");

	// Input can only be stalled while a result is pending
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with output free");

endmodule

bind card_access_permission_check capc_checker u_capc_checker (.*);

// ===== tb/tb_card_access_permission_check.sv =====
module tb_card_access_permission_check
	import capc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Operation codes the block must treat as undefined
	localparam logic [3:0] OP_UNDEF_LO = 4'd10;
	localparam logic [3:0] OP_UNDEF_HI = 4'd15;

	localparam int RANDOM_REQUESTS = 1000;
	localparam int MAX_REPORTS     = 10;

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                in_valid      = 1'b0;
	logic                in_stall;
	logic [BLK_W-1:0]    block_number  = '0;
	logic                key_sel       = 1'b0;
	logic [3:0]          operation     = '0;
	logic [7:0]          access_byte_b = '0;
	logic [7:0]          access_byte_c = '0;
	logic                out_valid;
	logic                out_stall     = 1'b0;
	logic                allowed;
	logic                value_block;
	logic                trailer_block;
	logic [SECTOR_W-1:0] sector_index;

	// Hand-written expectation travels with the request it belongs to
	logic    use_typed    = 1'b0;
	result_t typed_result = '0;

	typedef struct {
		result_t          res;
		logic [BLK_W-1:0] blk;
		logic [3:0]       op;
	} permission_t;

	permission_t pending_permissions[$];
	int          mismatch_count = 0;
	int          cycle_count    = 0;
	int          stall_left     = 0;

	card_access_permission_check dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.block_number  (block_number),
		.key_sel       (key_sel),
		.operation     (operation),
		.access_byte_b (access_byte_b),
		.access_byte_c (access_byte_c),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.allowed       (allowed),
		.value_block   (value_block),
		.trailer_block (trailer_block),
		.sector_index  (sector_index)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("Verification failed");
		$finish;
	end

	// Expected permission for one request: sector layout, group bits, rule tables
	function automatic result_t check_permission(logic [7:0] blk, logic kb, logic [3:0] op_raw,
			logic [7:0] ab, logic [7:0] ac_c);
		logic       small_sec;
		logic       is_trailer;
		logic [1:0] grp;
		ac_t        bits;
		op_t        op;
		result_t    r;
		op         = op_t'(op_raw);
		small_sec  = !blk[7];
		is_trailer = small_sec ? (blk[1:0] == 2'd3) : (blk[3:0] == 4'hF);
		r = '0;
		r.trailer_block = is_trailer;
		r.sector_index  = small_sec ? {1'b0, blk[6:2]} : {3'b100, blk[6:4]};
		if (is_trailer)
			grp = 2'd3;
		else if (small_sec)
			grp = blk[1:0];
		else if (blk[3:0] < 4'd5)
			grp = 2'd0;
		else if (blk[3:0] < 4'd10)
			grp = 2'd1;
		else
			grp = 2'd2;
		// {C1, C2, C3} of the group
		bits = {ab[4 + grp], ac_c[grp], ac_c[4 + grp]};
		if (is_trailer) begin
			case (op)
				OP_KEYA_WRITE, OP_KEYB_WRITE: begin
					r.allowed = kb ? (bits == 3'd0 || bits == 3'd1 || bits == 3'd3 || bits == 3'd4)
						: (bits == 3'd0 || bits == 3'd1);
				end
				OP_KEYB_READ: r.allowed = (bits <= 3'd2);
				OP_AC_READ:   r.allowed = 1'b1;
				OP_AC_WRITE: begin
					r.allowed = kb ? (bits == 3'd1 || bits == 3'd3 || bits == 3'd5) : (bits == 3'd1);
				end
				default:      r.allowed = 1'b0;
			endcase
		end else begin
			case (op)
				OP_DATA_READ: begin
					r.allowed = kb ? (bits != 3'd7) : !(bits == 3'd3 || bits == 3'd5 || bits == 3'd7);
				end
				OP_DATA_WRITE: begin
					r.allowed = kb ? (bits == 3'd0 || bits == 3'd3 || bits == 3'd4 || bits == 3'd6)
						: (bits == 3'd0);
					// block zero holds the manufacturer data
					if (blk == '0)
						r.allowed = 1'b0;
				end
				OP_DATA_INC:  r.allowed = kb ? (bits == 3'd0 || bits == 3'd6) : (bits == 3'd0);
				OP_DATA_DEC:  r.allowed = (bits == 3'd0 || bits == 3'd1 || bits == 3'd6);
				default:      r.allowed = 1'b0;
			endcase
			r.value_block = (bits == 3'b110 || bits == 3'b001);
		end
		return r;
	endfunction

	// Random output stall: calm stretches, short stalls, a few long ones
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if ((cycle_count % 600) < 150) begin
			out_stall <= 1'b0;
		end else begin
			case ($urandom_range(0, 99)) inside
				[0:64]:  out_stall <= 1'b0;
				[65:94]: begin
					stall_left <= $urandom_range(0, 2);
					out_stall  <= 1'b1;
				end
				default: begin
					stall_left <= $urandom_range(10, 30);
					out_stall  <= 1'b1;
				end
			endcase
		end
	end

	// Record each accepted request, check each accepted result against the oldest one
	always @(posedge clk) begin : permission_monitor
		permission_t req;
		permission_t exp;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				req.res = use_typed ? typed_result : check_permission(block_number, key_sel,
					operation, access_byte_b, access_byte_c);
				req.blk = block_number;
				req.op  = operation;
				pending_permissions.push_back(req);
			end
			if (out_valid && !out_stall) begin
				if (pending_permissions.size() == 0) begin
					mismatch_count = mismatch_count + 1;
					if (mismatch_count <= MAX_REPORTS)
						$display("unexpected result: allowed=%0d value=%0d trailer=%0d sector=%0d",
							allowed, value_block, trailer_block, sector_index);
				end else begin
					exp = pending_permissions.pop_front();
					if (allowed !== exp.res.allowed || value_block !== exp.res.value_block
							|| trailer_block !== exp.res.trailer_block
							|| sector_index !== exp.res.sector_index) begin
						mismatch_count = mismatch_count + 1;
						if (mismatch_count <= MAX_REPORTS)
							$display("mismatch blk=%0d op=%0d: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
								exp.blk, exp.op, exp.res.allowed, exp.res.value_block,
								exp.res.trailer_block, exp.res.sector_index,
								allowed, value_block, trailer_block, sector_index);
					end
				end
			end
		end
	end

	typedef struct {
		logic [7:0] blk;
		logic       kb;
		logic [3:0] op;
		logic [7:0] b;
		logic [7:0] c;
		logic       typed;
		result_t    res;
	} access_row_t;

	// Directed requests; typed rows carry their own expectation {allowed, value, trailer, sector}
	access_row_t access_rows [24] = '{
		// block zero write denied even where the bits allow it
		'{8'd0,   1'b1, OP_DATA_WRITE, 8'h00, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b0, 6'd0}},
		'{8'd0,   1'b0, OP_DATA_READ,  8'h00, 8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 6'd0}},
		// last block of the card, largest sector
		'{8'd255, 1'b0, OP_AC_READ,    8'hFF, 8'hFF, 1'b1, '{1'b1, 1'b0, 1'b1, 6'd39}},
		// data operation on a trailer
		'{8'd255, 1'b0, OP_DATA_READ,  8'hFF, 8'hFF, 1'b1, '{1'b0, 1'b0, 1'b1, 6'd39}},
		// key A is never readable
		'{8'd3,   1'b1, OP_KEYA_READ,  8'h00, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b1, 6'd0}},
		'{8'd127, 1'b0, OP_AC_READ,    8'h00, 8'h00, 1'b1, '{1'b1, 1'b0, 1'b1, 6'd31}},
		'{8'd128, 1'b1, OP_DATA_READ,  8'h00, 8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 6'd32}},
		// trailer operation on a data block
		'{8'd1,   1'b0, OP_KEYA_READ,  8'h00, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b0, 6'd0}},
		// undefined operations
		'{8'd5,   1'b0, OP_UNDEF_HI,   8'h00, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b0, 6'd1}},
		'{8'd7,   1'b1, OP_UNDEF_LO,   8'h00, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b1, 6'd1}},
		// value block bits on block zero, write still denied
		'{8'd0,   1'b1, OP_DATA_WRITE, 8'h10, 8'h01, 1'b1, '{1'b0, 1'b1, 1'b0, 6'd0}},
		// value block bits in the data groups never mark a trailer
		'{8'd3,   1'b0, OP_AC_READ,    8'h00, 8'h70, 1'b1, '{1'b1, 1'b0, 1'b1, 6'd0}},
		'{8'd133, 1'b1, OP_DATA_INC,   8'h20, 8'h02, 1'b0, '0},
		'{8'd142, 1'b0, OP_DATA_DEC,   8'h40, 8'h44, 1'b0, '0},
		'{8'd132, 1'b1, OP_DATA_DEC,   8'h00, 8'h10, 1'b0, '0},
		'{8'd143, 1'b0, OP_KEYA_WRITE, 8'h80, 8'h00, 1'b0, '0},
		'{8'd143, 1'b1, OP_KEYB_WRITE, 8'h00, 8'h08, 1'b0, '0},
		'{8'd11,  1'b0, OP_KEYB_READ,  8'h00, 8'h80, 1'b0, '0},
		'{8'd11,  1'b0, OP_AC_WRITE,   8'h00, 8'h80, 1'b0, '0},
		'{8'd11,  1'b1, OP_AC_WRITE,   8'h80, 8'h80, 1'b0, '0},
		'{8'd2,   1'b1, OP_DATA_WRITE, 8'h40, 8'h04, 1'b0, '0},
		'{8'd126, 1'b0, OP_DATA_READ,  8'hFF, 8'hFF, 1'b0, '0},
		'{8'd254, 1'b1, OP_DATA_DEC,   8'hAA, 8'h55, 1'b0, '0},
		'{8'd200, 1'b0, OP_DATA_WRITE, 8'h5A, 8'hA5, 1'b0, '0}
	};

	// Present one request and hold it until the transfer happens
	task automatic send_request(logic [7:0] blk, logic kb, logic [3:0] op, logic [7:0] b,
			logic [7:0] c, logic typed, result_t res);
		block_number  <= blk;
		key_sel       <= kb;
		operation     <= op;
		access_byte_b <= b;
		access_byte_c <= c;
		use_typed     <= typed;
		typed_result  <= res;
		in_valid      <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Idle cycles before the next request: none in quiet stretches, else mostly short
	task automatic request_gap(bit quiet);
		int gap;
		if (quiet)
			gap = 0;
		else if ($urandom_range(0, 99) < 60)
			gap = 0;
		else if ($urandom_range(0, 9) < 8)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(8, 30);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_permissions.size() != 0);
	endtask

	initial begin : request_driver
		logic [7:0] blk;
		logic [3:0] op;
		logic       is_trailer;
		int         pick;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (access_rows[i]) begin
			request_gap(i < 12);
			send_request(access_rows[i].blk, access_rows[i].kb, access_rows[i].op,
				access_rows[i].b, access_rows[i].c, access_rows[i].typed, access_rows[i].res);
		end
		drain_results();

		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			// sender holds off once mid-run until every result is back
			if (i == RANDOM_REQUESTS / 2)
				drain_results();
			request_gap(((i / 80) % 5) == 2);
			blk = ($urandom_range(0, 99) < 3) ? 8'd0 : 8'($urandom_range(0, 255));
			is_trailer = blk[7] ? (blk[3:0] == 4'hF) : (blk[1:0] == 2'd3);
			pick = $urandom_range(0, 99);
			// mostly the operation kind that matches the block
			if (pick < 75)
				op = is_trailer ? 4'($urandom_range(OP_KEYA_READ, OP_AC_WRITE))
					: 4'($urandom_range(OP_DATA_READ, OP_DATA_DEC));
			else if (pick < 95)
				op = 4'($urandom_range(OP_DATA_READ, OP_AC_WRITE));
			else
				op = 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
			send_request(blk, 1'($urandom_range(0, 1)), op, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 1'b0, '0);
		end
		drain_results();
		repeat (8) @(posedge clk);

		if (mismatch_count == 0 && pending_permissions.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
